// ----- sv/sxump_pkg.sv -----
// Package: shared types and constants for the SysEx USB-MIDI packetiser.
package sxump_pkg;

    localparam logic [2:0] CIN_WHOLE3 = 3'h3;
    localparam logic [2:0] CIN_CONT   = 3'h4;
    localparam logic [2:0] CIN_END1   = 3'h5;
    localparam logic [2:0] CIN_END2   = 3'h6;
    localparam logic [2:0] CIN_END3   = 3'h7;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0] code_index;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [7:0] third_data;
        logic       packet_last;
    } pkt_t;

    typedef struct packed {
        logic [1:0] n;
        pkt_t       pkt_a;
        pkt_t       pkt_b;
    } push_t;

endpackage

// ----- sv/sxump_packer.sv -----
// Packer: held group state and next-packet logic for each accepted byte.
module sxump_packer import sxump_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output push_t       push
);

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] count_reg, count_next;
    logic       nps_reg, nps_next;

    logic       full;
    logic [1:0] idx;
    logic [1:0] cnt_new;
    logic       nps_eff;
    pkt_t       grp_pkt, tail_pkt;

    always_comb begin
        full    = (count_reg == 2'd3);
        idx     = full ? 2'd0 : count_reg;
        cnt_new = idx + 2'd1;
        nps_eff = full ? 1'b0 : nps_reg;

        for (int i = 0; i < 3; i++) begin
            held_next[i] = (idx == 2'(i)) ? data_byte : held_reg[i];
        end

        grp_pkt.code_index  = CIN_CONT;
        grp_pkt.first_data  = held_reg[0];
        grp_pkt.second_data = held_reg[1];
        grp_pkt.third_data  = held_reg[2];
        grp_pkt.packet_last = 1'b0;

        tail_pkt.first_data  = held_next[0];
        tail_pkt.second_data = 8'h00;
        tail_pkt.third_data  = 8'h00;
        tail_pkt.packet_last = 1'b1;
        unique case (cnt_new)
            2'd1: tail_pkt.code_index = CIN_END1;
            2'd2: begin
                tail_pkt.code_index  = CIN_END2;
                tail_pkt.second_data = held_next[1];
            end
            default: begin
                tail_pkt.code_index  = nps_eff ? CIN_WHOLE3 : CIN_END3;
                tail_pkt.second_data = held_next[1];
                tail_pkt.third_data  = held_next[2];
            end
        endcase

        push.n     = 2'd0;
        push.pkt_a = tail_pkt;
        push.pkt_b = tail_pkt;
        if (accept) begin
            push.n = {1'b0, full} + {1'b0, end_of_message};
            if (full) begin
                push.pkt_a = grp_pkt;
            end
        end

        if (end_of_message) begin
            count_next = 2'd0;
            nps_next   = 1'b1;
        end else begin
            count_next = cnt_new;
            nps_next   = nps_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            nps_reg   <= 1'b1;
        end else if (accept) begin
            count_reg <= count_next;
            nps_reg   <= nps_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
    end

endmodule

// ----- sv/sxump_queue.sv -----
// Output queue: four packet slots, up to two pushes and one pop per cycle.
module sxump_queue import sxump_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output pkt_t  out_pkt
);

    pkt_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              pop;

    assign room      = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_pkt   = slot_reg[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = wr_reg + QPTR_W'(push.n);
        rd_next  = rd_reg + QPTR_W'(pop);
        cnt_next = cnt_reg + QCNT_W'(push.n) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            slot_reg[wr_reg] <= push.pkt_a;
        end
        if (push.n == 2'd2) begin
            slot_reg[wr_reg + QPTR_W'(1)] <= push.pkt_b;
        end
    end

endmodule

// ----- sv/sysex_usb_midi_packetizer_top.sv -----
// Top level: SysEx byte stream in, USB-MIDI event packets out.
//
//  channel | dir | payload
//  s_*     | in  | tdata[7:0] data byte, tlast end of message
//  m_*     | out | tdata code index, three data bytes; tlast final packet
//
// One byte per cycle while s_tready is high. A packet is queued when the
// byte that releases it is accepted; an end-marked full-group byte yields two.
// s_tready drops while the four-slot output queue has fewer than two free
// slots, so a stalled m_ side halts s_ once three packets are waiting.
// Synchronous active-low reset empties the queue and clears the held group.
module sysex_usb_midi_packetizer_top import sxump_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [2:0] code_index, [10:3] first_data,
                                   // [18:11] second_data, [26:19] third_data
    output logic        m_tlast    // packet_last
);

    push_t push;
    pkt_t  head;
    logic  room;
    logic  accept;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    sxump_packer u_packer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_byte      (s_tdata),
        .end_of_message (s_tlast),
        .push           (push)
    );

    sxump_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pkt   (head)
    );

    assign m_tdata = {5'd0, head.third_data, head.second_data, head.first_data,
                      head.code_index};
    assign m_tlast = head.packet_last;

endmodule

// ----- tb/sv/sysex_usb_midi_packetizer_top_tb.sv -----
// Self-checking testbench: SysEx bytes in, USB-MIDI event packets checked against a packer model.
`timescale 1ns / 1ps

module sysex_usb_midi_packetizer_top_tb;
    import sxump_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int ITEMS_PER_RUN = 176;
    localparam int DRAIN_CYCLES  = 20;
    localparam pkt_t NO_PKT      = '0;

    typedef struct {
        logic [7:0] data;
        logic       eom;
        bit         typed;
        int         n;
        pkt_t       p0;
        pkt_t       p1;
    } byte_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // packer state
    logic [7:0] grp_bytes [3];
    int         grp_cnt   = 0;
    bit         msg_fresh = 1'b1;

    pkt_t pending_pkts[$];
    pkt_t want;
    int   mismatches   = 0;
    int   cycles       = 0;
    int   src_idle_pct = 32;
    int   dst_stall_pct = 47;

    sysex_usb_midi_packetizer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic pkt_t mk_pkt(input logic [2:0] cin, input logic [7:0] b0,
                                    input logic [7:0] b1, input logic [7:0] b2,
                                    input logic last);
        pkt_t p;
        p.code_index  = cin;
        p.first_data  = b0;
        p.second_data = b1;
        p.third_data  = b2;
        p.packet_last = last;
        return p;
    endfunction

    // Returns the number of packets the byte releases, in order in p0 then p1.
    function automatic int pack_byte(input logic [7:0] b, input logic eom,
                                     output pkt_t p0, output pkt_t p1);
        int   n;
        pkt_t tail;
        n  = 0;
        p0 = NO_PKT;
        p1 = NO_PKT;
        if (grp_cnt == 3) begin
            p0 = mk_pkt(CIN_CONT, grp_bytes[0], grp_bytes[1], grp_bytes[2], 1'b0);
            n = 1;
            grp_cnt = 0;
            msg_fresh = 1'b0;
        end
        grp_bytes[grp_cnt] = b;
        grp_cnt++;
        if (eom) begin
            case (grp_cnt)
                1: tail = mk_pkt(CIN_END1, grp_bytes[0], 8'h00, 8'h00, 1'b1);
                2: tail = mk_pkt(CIN_END2, grp_bytes[0], grp_bytes[1], 8'h00, 1'b1);
                default: begin
                    tail = mk_pkt(msg_fresh ? CIN_WHOLE3 : CIN_END3, grp_bytes[0],
                                  grp_bytes[1], grp_bytes[2], 1'b1);
                end
            endcase
            if (n == 0) p0 = tail;
            else p1 = tail;
            n++;
            grp_cnt = 0;
            msg_fresh = 1'b1;
        end
        return n;
    endfunction

    task automatic queue_pkts(input int n, input pkt_t p0, input pkt_t p1);
        if (n >= 1) pending_pkts.push_back(p0);
        if (n == 2) pending_pkts.push_back(p1);
    endtask

    // Returns at the edge where the transaction is accepted.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pkts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected packet: tdata=%08h tlast=%0b", m_tdata, m_tlast);
            end else begin
                want = pending_pkts.pop_front();
                if ({m_tdata, m_tlast} !== {5'b0, want.third_data, want.second_data,
                                            want.first_data, want.code_index,
                                            want.packet_last}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("exp %0h %02h %02h %02h %0b got %0h %02h %02h %02h %0b pad %0h",
                                 want.code_index, want.first_data, want.second_data,
                                 want.third_data, want.packet_last, m_tdata[2:0],
                                 m_tdata[10:3], m_tdata[18:11], m_tdata[26:19], m_tlast,
                                 m_tdata[31:27]);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    initial begin
        byte_row_t  dir_rows[$];
        byte_row_t  r;
        pkt_t       p0;
        pkt_t       p1;
        int         n;
        int         sent;
        int         msg_len;
        int         sel;

        // single bytes at both extremes
        dir_rows.push_back('{8'h00, 1'b1, 1'b1, 1,
                             mk_pkt(CIN_END1, 8'h00, 8'h00, 8'h00, 1'b1), NO_PKT});
        dir_rows.push_back('{8'hFF, 1'b1, 1'b1, 1,
                             mk_pkt(CIN_END1, 8'hFF, 8'h00, 8'h00, 1'b1), NO_PKT});
        // two-byte tail
        dir_rows.push_back('{8'hF0, 1'b0, 1'b1, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'hF7, 1'b1, 1'b1, 1,
                             mk_pkt(CIN_END2, 8'hF0, 8'hF7, 8'h00, 1'b1), NO_PKT});
        // whole three-byte message
        dir_rows.push_back('{8'h00, 1'b0, 1'b1, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'hFF, 1'b0, 1'b1, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'hAA, 1'b1, 1'b1, 1,
                             mk_pkt(CIN_WHOLE3, 8'h00, 8'hFF, 8'hAA, 1'b1), NO_PKT});
        // full group and end mark on the same byte
        dir_rows.push_back('{8'hF0, 1'b0, 1'b1, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h01, 1'b0, 1'b1, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h02, 1'b0, 1'b1, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h03, 1'b1, 1'b1, 2,
                             mk_pkt(CIN_CONT, 8'hF0, 8'h01, 8'h02, 1'b0),
                             mk_pkt(CIN_END1, 8'h03, 8'h00, 8'h00, 1'b1)});
        // three-byte tail after a continue packet, then a two-byte one
        dir_rows.push_back('{8'hF0, 1'b0, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h7F, 1'b0, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h00, 1'b0, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h55, 1'b0, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'hAA, 1'b0, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'hF7, 1'b1, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h01, 1'b0, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h02, 1'b0, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h03, 1'b0, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h04, 1'b0, 1'b0, 0, NO_PKT, NO_PKT});
        dir_rows.push_back('{8'h05, 1'b1, 1'b0, 0, NO_PKT, NO_PKT});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            send_byte(r.data, r.eom);
            n = pack_byte(r.data, r.eom, p0, p1);
            if (r.typed) queue_pkts(r.n, r.p0, r.p1);
            else queue_pkts(n, p0, p1);
        end

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct  = (ph == 0) ? 32 : (ph == 1) ? 47 : 0;
            dst_stall_pct = (ph == 0) ? 47 : (ph == 1) ? 32 : 0;
            sent = 0;
            while (sent < ITEMS_PER_RUN) begin
                sel = $urandom_range(99);
                if (sel < 70) msg_len = $urandom_range(1, 7);
                else if (sel < 95) msg_len = $urandom_range(8, 16);
                else msg_len = $urandom_range(17, 48);
                for (int k = 0; k < msg_len; k++) begin
                    r.data = 8'($urandom_range(255));
                    r.eom  = (k == msg_len - 1);
                    send_byte(r.data, r.eom);
                    n = pack_byte(r.data, r.eom, p0, p1);
                    queue_pkts(n, p0, p1);
                    sent++;
                end
            end
        end
        s_tvalid <= 1'b0;

        while (pending_pkts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_pkts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
